// ----- hw/rtl/card_message_deframer_macros.svh -----
// Assertion macros for the card message deframer.
`ifndef CARD_MESSAGE_DEFRAMER_MACROS_SVH
`define CARD_MESSAGE_DEFRAMER_MACROS_SVH
`ifndef SYNTH
`define CMD_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define CMD_ASSERT_NORST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define CMD_ASSERT_IMPL(label, clk, rst_n, prop)
`define CMD_ASSERT_NORST(label, clk, prop)
`endif
`endif

// ----- hw/rtl/cmd_pkg.sv -----
// ----------------------------------------------------------------------------
// Card message deframer package
// Section codes, field definition tables and the usable-field mask.
// ----------------------------------------------------------------------------
package cmd_pkg;

    localparam int HEADER_BYTES = 46;
    localparam int FIELD_COUNT  = 128;

    typedef enum logic [2:0] {
        SEC_HEADER  = 3'd0,
        SEC_TYPE    = 3'd1,
        SEC_BITMAP  = 3'd2,
        SEC_PREFIX  = 3'd3,
        SEC_DATA    = 3'd4,
        SEC_OUTSIDE = 3'd5
    } t_section;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_HEADER = 2'd1,
        ERR_PREFIX = 2'd2
    } t_error;

    typedef struct packed {
        logic [7:0]  byte_out;
        t_section    section;
        logic [7:0]  field_number;
        logic [9:0]  field_offset;
        logic        field_last;
        logic        message_done;
        t_error      error_code;
    } t_result;

    function automatic logic [9:0] field_max(input logic [6:0] idx);
        logic [9:0] v;
        v = 10'd0;
        case (idx)
            7'd0: v = 10'd16;   7'd1: v = 10'd19;   7'd2: v = 10'd6;
            7'd3: v = 10'd12;   7'd4: v = 10'd12;   7'd5: v = 10'd12;
            7'd6: v = 10'd10;   7'd8: v = 10'd8;    7'd9: v = 10'd8;
            7'd10: v = 10'd6;   7'd11: v = 10'd6;   7'd12: v = 10'd4;
            7'd13: v = 10'd4;   7'd14: v = 10'd4;   7'd15: v = 10'd4;
            7'd17: v = 10'd4;   7'd18: v = 10'd3;   7'd21: v = 10'd3;
            7'd22: v = 10'd3;   7'd24: v = 10'd2;   7'd25: v = 10'd2;
            7'd27: v = 10'd9;   7'd28: v = 10'd9;   7'd29: v = 10'd9;
            7'd30: v = 10'd9;   7'd31: v = 10'd11;  7'd32: v = 10'd11;
            7'd34: v = 10'd37;  7'd35: v = 10'd104; 7'd36: v = 10'd12;
            7'd37: v = 10'd6;   7'd38: v = 10'd2;   7'd40: v = 10'd8;
            7'd41: v = 10'd15;  7'd42: v = 10'd40;  7'd43: v = 10'd25;
            7'd44: v = 10'd76;  7'd47: v = 10'd512; 7'd48: v = 10'd3;
            7'd49: v = 10'd3;   7'd50: v = 10'd3;   7'd51: v = 10'd8;
            7'd52: v = 10'd16;  7'd53: v = 10'd40;  7'd54: v = 10'd255;
            7'd55: v = 10'd512; 7'd56: v = 10'd100; 7'd58: v = 10'd600;
            7'd59: v = 10'd100; 7'd60: v = 10'd200; 7'd61: v = 10'd200;
            7'd62: v = 10'd512; 7'd69: v = 10'd3;   7'd89: v = 10'd42;
            7'd95: v = 10'd8;   7'd99: v = 10'd11;  7'd101: v = 10'd28;
            7'd102: v = 10'd28; 7'd103: v = 10'd512; 7'd112: v = 10'd512;
            7'd115: v = 10'd512; 7'd116: v = 10'd256; 7'd120: v = 10'd100;
            7'd121: v = 10'd100; 7'd122: v = 10'd100; 7'd124: v = 10'd256;
            7'd125: v = 10'd256; 7'd127: v = 10'd8;
            default: v = 10'd0;
        endcase
        return v;
    endfunction

    function automatic logic [1:0] field_digits(input logic [6:0] idx);
        logic [1:0] d;
        d = 2'd0;
        case (idx)
            7'd1, 7'd31, 7'd32, 7'd34, 7'd43, 7'd44, 7'd99, 7'd101,
            7'd102: d = 2'd2;
            7'd35, 7'd45, 7'd46, 7'd47, 7'd53, 7'd54, 7'd55, 7'd56, 7'd58,
            7'd59, 7'd60, 7'd61, 7'd62, 7'd103, 7'd112, 7'd115, 7'd116,
            7'd120, 7'd121, 7'd122, 7'd124, 7'd125: d = 2'd3;
            default: d = 2'd0;
        endcase
        return d;
    endfunction

    // Fields that are ever parsed: a prefix or a nonzero fixed size.
    function automatic logic [FIELD_COUNT-1:0] field_usable();
        logic [FIELD_COUNT-1:0] m;
        m = '0;
        for (int i = 0; i < FIELD_COUNT; i++) begin
            m[i] = (field_digits(7'(i)) != 2'd0) || (field_max(7'(i)) != 10'd0);
        end
        return m;
    endfunction

    localparam logic [FIELD_COUNT-1:0] FIELD_USABLE = field_usable();

endpackage

// ----- hw/rtl/cmd_next_field.sv -----
// ----------------------------------------------------------------------------
// Next field search
// Priority encoder over the present, usable fields at or above a start field.
// ----------------------------------------------------------------------------
module cmd_next_field
    import cmd_pkg::*;
(
    input  logic [127:0] i_flags,
    input  logic         i_extended,
    input  logic [7:0]   i_from,
    output logic [7:0]   o_field
);

    logic [FIELD_COUNT-1:0] w_cand;

    always_comb begin
        for (int i = 0; i < FIELD_COUNT; i++) begin
            w_cand[i] = i_flags[127 - i] && FIELD_USABLE[i] && (i >= 1)
                        && ((i + 1) >= int'(i_from))
                        && (i_extended || (i < 64));
        end
        o_field = 8'd0;
        for (int i = FIELD_COUNT - 1; i >= 0; i--) begin
            if (w_cand[i]) begin
                o_field = 8'(i + 1);
            end
        end
    end

endmodule

// ----- hw/rtl/cmd_parse_core.sv -----
// ----------------------------------------------------------------------------
// Deframer parse core
// Section state, counters and bitmap; computes one tagged result per byte.
// ----------------------------------------------------------------------------
`include "card_message_deframer_macros.svh"
module cmd_parse_core
    import cmd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic       i_start,
    input  logic [7:0] i_header_code,
    output t_result    o_result
);

    t_section         r_phase, n_phase;
    logic [9:0]       r_count, n_count;
    logic [127:0]     r_flags, n_flags;
    logic             r_ext, n_ext;
    logic [7:0]       r_field, n_field;
    logic [1:0]       r_digits, n_digits;
    logic [9:0]       r_pval, n_pval;
    logic             r_nondig, n_nondig;
    logic [9:0]       r_left, n_left;

    t_section         w_phase;
    logic [9:0]       w_count;
    logic [127:0]     w_flags;
    logic             w_ext;
    logic [7:0]       w_field;
    logic [1:0]       w_digits;
    logic [9:0]       w_pval;
    logic             w_nondig;
    logic [9:0]       w_left;
    logic [7:0]       w_from;
    logic [7:0]       w_next;
    logic [6:0]       w_idx;
    logic [3:0]       w_bidx;
    logic [9:0]       w_pnew;
    logic [13:0]      w_pmul;
    t_result          w_res;

    cmd_next_field u_next (
        .i_flags    (n_flags),
        .i_extended (n_ext),
        .i_from     (w_from),
        .o_field    (w_next)
    );

    always_comb begin
        w_phase  = r_phase;
        w_count  = r_count;
        w_flags  = r_flags;
        w_ext    = r_ext;
        w_field  = r_field;
        w_digits = r_digits;
        w_pval   = r_pval;
        w_nondig = r_nondig;
        w_left   = r_left;
        if (i_start) begin
            w_phase  = SEC_HEADER;
            w_count  = '0;
            w_flags  = '0;
            w_ext    = 1'b0;
            w_field  = '0;
            w_digits = '0;
            w_pval   = '0;
            w_nondig = 1'b0;
            w_left   = '0;
        end

        n_phase  = w_phase;
        n_count  = w_count;
        n_flags  = w_flags;
        n_ext    = w_ext;
        n_field  = w_field;
        n_digits = w_digits;
        n_pval   = w_pval;
        n_nondig = w_nondig;
        n_left   = w_left;
        w_from   = 8'd2;
        w_idx    = 7'(w_field - 8'd1);
        w_bidx   = w_count[3:0];
        w_pmul   = 14'(w_pval) * 14'd10 + 14'(i_byte - 8'h30);
        w_pnew   = w_pval;

        w_res.byte_out     = i_byte;
        w_res.section      = w_phase;
        w_res.field_number = 8'd0;
        w_res.field_offset = w_count;
        w_res.field_last   = 1'b0;
        w_res.message_done = 1'b0;
        w_res.error_code   = ERR_NONE;

        case (w_phase)
            SEC_HEADER: begin
                if (w_count == 10'd0 && i_byte != i_header_code) begin
                    w_res.error_code   = ERR_HEADER;
                    w_res.field_last   = 1'b1;
                    w_res.message_done = 1'b1;
                    n_phase = SEC_OUTSIDE;
                    n_count = '0;
                end else if (w_count >= 10'(HEADER_BYTES - 1)) begin
                    w_res.field_last = 1'b1;
                    n_phase = SEC_TYPE;
                    n_count = '0;
                end else begin
                    n_count = w_count + 10'd1;
                end
            end
            SEC_TYPE: begin
                if (w_count >= 10'd3) begin
                    w_res.field_last = 1'b1;
                    n_phase = SEC_BITMAP;
                    n_count = '0;
                end else begin
                    n_count = w_count + 10'd1;
                end
            end
            SEC_BITMAP: begin
                if (w_count == 10'd0) begin
                    n_ext = i_byte[7];
                end
                n_flags[8*(15 - w_bidx) +: 8] = i_byte;
                if (w_count >= (n_ext ? 10'd15 : 10'd7)) begin
                    w_res.field_last = 1'b1;
                    n_count = '0;
                    w_from = 8'd2;
                    if (w_next == 8'd0) begin
                        n_phase = SEC_OUTSIDE;
                        w_res.message_done = 1'b1;
                    end else begin
                        n_field = w_next;
                        if (field_digits(7'(w_next - 8'd1)) != 2'd0) begin
                            n_phase  = SEC_PREFIX;
                            n_digits = field_digits(7'(w_next - 8'd1));
                            n_pval   = '0;
                            n_nondig = 1'b0;
                        end else begin
                            n_phase = SEC_DATA;
                            n_left  = field_max(7'(w_next - 8'd1));
                        end
                    end
                end else begin
                    n_count = w_count + 10'd1;
                end
            end
            SEC_PREFIX: begin
                w_res.field_number = w_field;
                if (!w_nondig && i_byte >= 8'h30 && i_byte <= 8'h39) begin
                    w_pnew = w_pmul[9:0];
                end else begin
                    n_nondig = 1'b1;
                end
                n_pval = w_pnew;
                w_from = w_field + 8'd1;
                if (w_digits <= 2'd1) begin
                    n_digits = '0;
                    w_res.field_last = 1'b1;
                    if (w_pnew > field_max(w_idx)) begin
                        w_res.error_code   = ERR_PREFIX;
                        w_res.message_done = 1'b1;
                        n_phase = SEC_OUTSIDE;
                        n_count = '0;
                    end else if (w_pnew == 10'd0) begin
                        n_count = '0;
                        if (w_next == 8'd0) begin
                            n_phase = SEC_OUTSIDE;
                            w_res.message_done = 1'b1;
                        end else begin
                            n_field = w_next;
                            if (field_digits(7'(w_next - 8'd1)) != 2'd0) begin
                                n_phase  = SEC_PREFIX;
                                n_digits = field_digits(7'(w_next - 8'd1));
                                n_pval   = '0;
                                n_nondig = 1'b0;
                            end else begin
                                n_phase = SEC_DATA;
                                n_left  = field_max(7'(w_next - 8'd1));
                            end
                        end
                    end else begin
                        n_left  = w_pnew;
                        n_phase = SEC_DATA;
                        n_count = '0;
                    end
                end else begin
                    n_digits = w_digits - 2'd1;
                    n_count  = w_count + 10'd1;
                end
            end
            SEC_DATA: begin
                w_res.field_number = w_field;
                w_from = w_field + 8'd1;
                if (w_left <= 10'd1) begin
                    n_left = '0;
                    w_res.field_last = 1'b1;
                    n_count = '0;
                    if (w_next == 8'd0) begin
                        n_phase = SEC_OUTSIDE;
                        w_res.message_done = 1'b1;
                    end else begin
                        n_field = w_next;
                        if (field_digits(7'(w_next - 8'd1)) != 2'd0) begin
                            n_phase  = SEC_PREFIX;
                            n_digits = field_digits(7'(w_next - 8'd1));
                            n_pval   = '0;
                            n_nondig = 1'b0;
                        end else begin
                            n_phase = SEC_DATA;
                            n_left  = field_max(7'(w_next - 8'd1));
                        end
                    end
                end else begin
                    n_left  = w_left - 10'd1;
                    n_count = w_count + 10'd1;
                end
            end
            default: begin
                w_res.section      = SEC_OUTSIDE;
                w_res.field_offset = '0;
                n_phase = SEC_OUTSIDE;
            end
        endcase
        o_result = w_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= SEC_OUTSIDE;
            r_count  <= '0;
            r_flags  <= '0;
            r_ext    <= 1'b0;
            r_field  <= '0;
            r_digits <= '0;
            r_pval   <= '0;
            r_nondig <= 1'b0;
            r_left   <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_flags  <= n_flags;
            r_ext    <= n_ext;
            r_field  <= n_field;
            r_digits <= n_digits;
            r_pval   <= n_pval;
            r_nondig <= n_nondig;
            r_left   <= n_left;
        end
    end

    `CMD_ASSERT_IMPL(a_data_has_field, i_clk, i_rst_n,
        (r_phase == SEC_DATA || r_phase == SEC_PREFIX) |-> (r_field >= 8'd2))
    `CMD_ASSERT_IMPL(a_done_leaves, i_clk, i_rst_n,
        (i_step && w_res.message_done) |=> (r_phase == SEC_OUTSIDE))
    `CMD_ASSERT_IMPL(a_err_done, i_clk, i_rst_n,
        (w_res.error_code != ERR_NONE) |-> w_res.message_done)

endmodule

// ----- hw/rtl/card_message_deframer.sv -----
// ----------------------------------------------------------------------------
// Card message deframer
// Tags each message byte with its section, field number and offset.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while the output is not stalled and returns
// one tagged result per byte, registered in the cycle after acceptance; the
// next present field is found by a priority encoder in the same cycle.
// A stalled result is held in the output register while the next byte waits.
`include "card_message_deframer_macros.svh"
module card_message_deframer
    import cmd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte_in,
    input  logic       i_msg_start,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte_out,
    output logic [2:0] o_section,
    output logic [7:0] o_field_number,
    output logic [9:0] o_field_offset,
    output logic       o_field_last,
    output logic       o_message_done,
    output logic [1:0] o_error_code
);

    logic [7:0] r_header_code;
    logic       r_valid;
    t_result    r_res;
    t_result    w_res;
    logic       w_acc;

    assign o_ready = !r_valid || i_ready;
    assign w_acc   = i_valid && o_ready;

    cmd_parse_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_acc),
        .i_byte        (i_byte_in),
        .i_start       (i_msg_start),
        .i_header_code (r_header_code),
        .o_result      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_code <= 8'd46;
            r_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_header_code <= i_cfg_data;
            end
            if (o_ready) begin
                r_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_res <= w_res;
        end
    end

    assign o_valid        = r_valid;
    assign o_byte_out     = r_res.byte_out;
    assign o_section      = r_res.section;
    assign o_field_number = r_res.field_number;
    assign o_field_offset = r_res.field_offset;
    assign o_field_last   = r_res.field_last;
    assign o_message_done = r_res.message_done;
    assign o_error_code   = r_res.error_code;

    `CMD_ASSERT_IMPL(a_hold, i_clk, i_rst_n,
        (r_valid && !i_ready) |=> (r_valid && $stable(r_res)))
    `CMD_ASSERT_IMPL(a_fill, i_clk, i_rst_n, w_acc |=> r_valid)
    `CMD_ASSERT_NORST(a_reset, i_clk, !i_rst_n |=> !r_valid)

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Card message deframer testbench
// Drives framed card messages byte by byte, predicts the tag of every byte
// and compares each result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb_top
    import cmd_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic [7:0] b;
        logic       st;
        logic       chk;
        t_result    res;
    } t_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [7:0] i_cfg_data;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_byte_in;
    logic       i_msg_start;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_byte_out;
    logic [2:0] o_section;
    logic [7:0] o_field_number;
    logic [9:0] o_field_offset;
    logic       o_field_last;
    logic       o_message_done;
    logic [1:0] o_error_code;

    card_message_deframer uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready), .i_byte_in(i_byte_in),
        .i_msg_start(i_msg_start), .o_valid(o_valid), .i_ready(i_ready),
        .o_byte_out(o_byte_out), .o_section(o_section), .o_field_number(o_field_number),
        .o_field_offset(o_field_offset), .o_field_last(o_field_last),
        .o_message_done(o_message_done), .o_error_code(o_error_code)
    );

    // Predictor state.
    logic [7:0]   hdr_code;
    t_section     phase;
    int unsigned  cnt;
    logic [127:0] bmap;
    logic         ext;
    int unsigned  cur_fld;
    int unsigned  digits_left;
    int unsigned  pfx_val;
    logic         pfx_stop;
    int unsigned  data_left;

    t_result      tag_queue[$];
    t_result      typed_queue[$];
    logic         typed_flag[$];
    int           errors;
    int           idle_cycles;
    logic         stim_done;

    // Byte-wise stimulus buffer.
    logic [7:0]   sb_byte[$];
    logic         sb_start[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned fmax_of(int unsigned n);
        int unsigned v;
        v = 0;
        case (n)
            1: v = 16; 2: v = 19; 3: v = 6; 4: v = 12; 5: v = 12; 6: v = 12; 7: v = 10;
            9: v = 8; 10: v = 8; 11: v = 6; 12: v = 6; 13: v = 4; 14: v = 4; 15: v = 4;
            16: v = 4; 18: v = 4; 19: v = 3; 22: v = 3; 23: v = 3; 25: v = 2; 26: v = 2;
            28: v = 9; 29: v = 9; 30: v = 9; 31: v = 9; 32: v = 11; 33: v = 11;
            35: v = 37; 36: v = 104; 37: v = 12; 38: v = 6; 39: v = 2; 41: v = 8;
            42: v = 15; 43: v = 40; 44: v = 25; 45: v = 76; 48: v = 512; 49: v = 3;
            50: v = 3; 51: v = 3; 52: v = 8; 53: v = 16; 54: v = 40; 55: v = 255;
            56: v = 512; 57: v = 100; 59: v = 600; 60: v = 100; 61: v = 200;
            62: v = 200; 63: v = 512; 70: v = 3; 90: v = 42; 96: v = 8; 100: v = 11;
            102: v = 28; 103: v = 28; 104: v = 512; 113: v = 512; 116: v = 512;
            117: v = 256; 121: v = 100; 122: v = 100; 123: v = 100; 125: v = 256;
            126: v = 256; 128: v = 8;
            default: v = 0;
        endcase
        return v;
    endfunction

    function automatic int unsigned fdig_of(int unsigned n);
        int unsigned d;
        d = 0;
        case (n)
            2, 32, 33, 35, 44, 45, 100, 102, 103: d = 2;
            36, 46, 47, 48, 54, 55, 56, 57, 59, 60, 61, 62, 63, 104, 113, 116, 117,
            121, 122, 123, 125, 126: d = 3;
            default: d = 0;
        endcase
        return d;
    endfunction

    function automatic int unsigned next_field(int unsigned from);
        int unsigned lim;
        lim = ext ? 128 : 64;
        for (int unsigned n = from; n <= lim; n++) begin
            if (bmap[128 - n] && (fdig_of(n) != 0 || fmax_of(n) != 0)) return n;
        end
        return 0;
    endfunction

    function automatic void open_field(input int unsigned f, inout logic done);
        cnt = 0;
        if (f == 0) begin
            phase = SEC_OUTSIDE;
            done = 1'b1;
        end else begin
            cur_fld = f;
            if (fdig_of(f) != 0) begin
                phase = SEC_PREFIX;
                digits_left = fdig_of(f);
                pfx_val = 0;
                pfx_stop = 1'b0;
            end else begin
                phase = SEC_DATA;
                data_left = fmax_of(f);
            end
        end
    endfunction

    function automatic void clear_msg();
        cnt = 0; bmap = '0; ext = 1'b0; cur_fld = 0; digits_left = 0;
        pfx_val = 0; pfx_stop = 1'b0; data_left = 0;
    endfunction

    function automatic t_result tag_byte(input logic [7:0] b, input logic st);
        t_result r;
        logic done;
        int unsigned nb;
        done = 1'b0;
        if (st) begin
            clear_msg();
            phase = SEC_HEADER;
        end
        r.byte_out = b; r.section = phase; r.field_number = 8'd0;
        r.field_offset = cnt[9:0]; r.field_last = 1'b0; r.error_code = ERR_NONE;
        case (phase)
            SEC_HEADER: begin
                if (cnt == 0 && b != hdr_code) begin
                    r.error_code = ERR_HEADER; r.field_last = 1'b1; done = 1'b1;
                    phase = SEC_OUTSIDE; cnt = 0;
                end else if (cnt >= HEADER_BYTES - 1) begin
                    r.field_last = 1'b1; phase = SEC_TYPE; cnt = 0;
                end else cnt++;
            end
            SEC_TYPE: begin
                if (cnt >= 3) begin
                    r.field_last = 1'b1; phase = SEC_BITMAP; cnt = 0;
                end else cnt++;
            end
            SEC_BITMAP: begin
                if (cnt == 0) ext = b[7];
                bmap[127 - 8 * (cnt % 16) -: 8] = b;
                nb = ext ? 16 : 8;
                if (cnt >= nb - 1) begin
                    r.field_last = 1'b1;
                    open_field(next_field(2), done);
                end else cnt++;
            end
            SEC_PREFIX: begin
                r.field_number = cur_fld[7:0];
                if (!pfx_stop && b >= "0" && b <= "9")
                    pfx_val = (pfx_val * 10 + (b - "0")) % 1024;
                else pfx_stop = 1'b1;
                if (digits_left <= 1) begin
                    digits_left = 0;
                    r.field_last = 1'b1;
                    if (pfx_val > fmax_of(cur_fld)) begin
                        r.error_code = ERR_PREFIX; done = 1'b1;
                        phase = SEC_OUTSIDE; cnt = 0;
                    end else if (pfx_val == 0) begin
                        open_field(next_field(cur_fld + 1), done);
                    end else begin
                        data_left = pfx_val; phase = SEC_DATA; cnt = 0;
                    end
                end else begin
                    digits_left--; cnt++;
                end
            end
            SEC_DATA: begin
                r.field_number = cur_fld[7:0];
                if (data_left <= 1) begin
                    data_left = 0; r.field_last = 1'b1;
                    open_field(next_field(cur_fld + 1), done);
                end else begin
                    data_left--; cnt++;
                end
            end
            default: begin
                r.section = SEC_OUTSIDE; r.field_offset = 10'd0; phase = SEC_OUTSIDE;
            end
        endcase
        r.message_done = done;
        return r;
    endfunction

    // Builds one message into the stimulus buffer.
    task automatic put_msg(input logic [7:0] code, input logic bigmap,
                           input int unsigned density, input logic mangle);
        logic [127:0] bm;
        int unsigned nb, len, nd, lim;
        sb_byte.push_back(code); sb_start.push_back(1'b1);
        for (int i = 1; i < HEADER_BYTES + 4; i++) begin
            sb_byte.push_back(8'($urandom)); sb_start.push_back(1'b0);
        end
        for (int i = 0; i < 128; i++) bm[i] = ($urandom_range(99, 0) < density);
        bm[127] = bigmap;
        nb = bigmap ? 16 : 8;
        for (int i = 0; i < nb; i++) begin
            sb_byte.push_back(bm[127 - 8 * i -: 8]); sb_start.push_back(1'b0);
        end
        lim = bigmap ? 128 : 64;
        for (int unsigned n = 2; n <= lim; n++) begin
            if (!bm[128 - n]) continue;
            nd = fdig_of(n);
            if (nd != 0) begin
                len = $urandom_range(fmax_of(n) < 20 ? fmax_of(n) : 20, 0);
                if (mangle && $urandom_range(3, 0) == 0) len = fmax_of(n) + 1;
                for (int d = nd - 1; d >= 0; d--) begin
                    sb_byte.push_back(8'("0" + (len / (d == 2 ? 100 : d == 1 ? 10 : 1)) % 10));
                    sb_start.push_back(1'b0);
                end
                if (mangle && $urandom_range(3, 0) == 0) sb_byte[$] = 8'($urandom);
            end else len = fmax_of(n);
            for (int k = 0; k < len; k++) begin
                sb_byte.push_back(8'($urandom)); sb_start.push_back(1'b0);
            end
        end
        if (mangle && $urandom_range(1, 0) == 0) begin
            for (int k = 0; k < $urandom_range(5, 1); k++) begin
                sb_byte.push_back(8'($urandom)); sb_start.push_back(1'b0);
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic st, input logic chk,
                             input t_result r);
        t_result p;
        i_valid <= 1'b1;
        i_byte_in <= b;
        i_msg_start <= st;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        p = tag_byte(b, st);
        tag_queue.push_back(p);
        typed_queue.push_back(r);
        typed_flag.push_back(chk);
    endtask

    task automatic drain_buffer();
        t_result z;
        int burst;
        z = '0;
        burst = 0;
        while (sb_byte.size() > 0) begin
            if (burst == 0) begin
                if ($urandom_range(3, 0) == 0) begin
                    i_valid <= 1'b0;
                    repeat ($urandom_range(4, 1)) @(posedge i_clk);
                end
                burst = $urandom_range(30, 1);
            end
            send_byte(sb_byte.pop_front(), sb_start.pop_front(), 1'b0, z);
            burst--;
        end
        i_valid <= 1'b0;
    endtask

    task automatic wait_empty();
        while (tag_queue.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_code(input logic [7:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        hdr_code = v;
    endtask

    // Receiver: stalls in a repeating, partly random pattern with periodic phases of no stall.
    initial begin
        int k;
        k = 0;
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            k++;
            if ((k / 300) % 3 == 2) i_ready <= 1'b1;
            else i_ready <= (k % 7 != 3) && (k % 11 != 5) && ($urandom_range(7, 0) != 0);
        end
    end

    // Checker.
    always @(posedge i_clk) begin
        t_result e, t;
        logic c;
        if (i_rst_n && o_valid && i_ready) begin
            if (tag_queue.size() == 0) begin
                $error("result with no request pending: byte %0h", o_byte_out);
                errors++;
            end else begin
                e = tag_queue.pop_front();
                t = typed_queue.pop_front();
                c = typed_flag.pop_front();
                if (c && t != e) begin
                    $error("typed row disagrees with prediction: %p vs %p", t, e);
                    errors++;
                end
                if (o_byte_out !== e.byte_out) begin
                    $error("byte_out exp %0h got %0h", e.byte_out, o_byte_out); errors++;
                end
                if (o_section !== e.section) begin
                    $error("section exp %0d got %0d", e.section, o_section); errors++;
                end
                if (o_field_number !== e.field_number) begin
                    $error("field_number exp %0d got %0d", e.field_number, o_field_number);
                    errors++;
                end
                if (o_field_offset !== e.field_offset) begin
                    $error("field_offset exp %0d got %0d", e.field_offset, o_field_offset);
                    errors++;
                end
                if (o_field_last !== e.field_last) begin
                    $error("field_last exp %0d got %0d", e.field_last, o_field_last); errors++;
                end
                if (o_message_done !== e.message_done) begin
                    $error("message_done exp %0d got %0d", e.message_done, o_message_done);
                    errors++;
                end
                if (o_error_code !== e.error_code) begin
                    $error("error_code exp %0d got %0d", e.error_code, o_error_code); errors++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else if (!stim_done) idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        t_row rows[$];
        int total;
        logic [7:0] codes[4];
        errors = 0;
        idle_cycles = 0;
        stim_done = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = 8'd0;
        i_valid = 1'b0;
        i_byte_in = 8'd0;
        i_msg_start = 1'b0;
        hdr_code = 8'd46;
        phase = SEC_OUTSIDE;
        clear_msg();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows: known results after reset, on header errors and on a valid header.
        rows.push_back('{8'hFF, 1'b0, 1'b1,
            '{8'hFF, SEC_OUTSIDE, 8'd0, 10'd0, 1'b0, 1'b0, ERR_NONE}});
        rows.push_back('{8'h00, 1'b0, 1'b1,
            '{8'h00, SEC_OUTSIDE, 8'd0, 10'd0, 1'b0, 1'b0, ERR_NONE}});
        rows.push_back('{8'h2F, 1'b1, 1'b1,
            '{8'h2F, SEC_HEADER, 8'd0, 10'd0, 1'b1, 1'b1, ERR_HEADER}});
        rows.push_back('{8'hAA, 1'b0, 1'b1,
            '{8'hAA, SEC_OUTSIDE, 8'd0, 10'd0, 1'b0, 1'b0, ERR_NONE}});
        rows.push_back('{8'd46, 1'b1, 1'b1,
            '{8'd46, SEC_HEADER, 8'd0, 10'd0, 1'b0, 1'b0, ERR_NONE}});
        rows.push_back('{8'h55, 1'b0, 1'b1,
            '{8'h55, SEC_HEADER, 8'd0, 10'd1, 1'b0, 1'b0, ERR_NONE}});
        rows.push_back('{8'd0, 1'b1, 1'b1,
            '{8'd0, SEC_HEADER, 8'd0, 10'd0, 1'b1, 1'b1, ERR_HEADER}});
        foreach (rows[i]) send_byte(rows[i].b, rows[i].st, rows[i].chk, rows[i].res);
        i_valid <= 1'b0;
        total = rows.size();
        wait_empty();

        // Directed messages: empty bitmap, full extended bitmap, prefix errors,
        // non-digit prefixes and a restart in mid-message.
        put_msg(8'd46, 1'b0, 0, 1'b0);
        put_msg(8'd46, 1'b1, 100, 1'b0);
        put_msg(8'd46, 1'b0, 30, 1'b1);
        put_msg(8'd46, 1'b1, 20, 1'b1);
        sb_byte.push_back(8'd46); sb_start.push_back(1'b1);
        for (int i = 0; i < 10; i++) begin
            sb_byte.push_back(8'($urandom)); sb_start.push_back(1'b0);
        end
        total += sb_byte.size();
        drain_buffer();
        wait_empty();

        // Random phases across several header codes, extremes included.
        codes = '{8'd0, 8'd255, 8'd46, 8'($urandom)};
        foreach (codes[c]) begin
            set_code(codes[c]);
            for (int m = 0; m == 0 || total < 1300 * (c + 1) / 4; m++) begin
                case ($urandom_range(9, 0))
                    0: put_msg(8'($urandom), 1'b0, 10, 1'b0);
                    1, 2: put_msg(codes[c], 1'b1, $urandom_range(25, 0), 1'b1);
                    default: put_msg(codes[c], $urandom_range(1, 0),
                                     $urandom_range(20, 0), 1'b0);
                endcase
                total += sb_byte.size();
                drain_buffer();
                if (m == 3) wait_empty();
            end
            wait_empty();
        end

        stim_done = 1'b1;
        repeat (20) @(posedge i_clk);
        if (errors == 0 && tag_queue.size() == 0) begin
            $display("status: pass");
        end else begin
            if (tag_queue.size() != 0) $error("%0d results never arrived", tag_queue.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule
